### rtl/tcw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: field widths,
// function codes, character codes, sequencer states and cursor commands.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // screen geometry defaults
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // field widths
    localparam int FUNC_W    = 2;
    localparam int CHAR_W    = 8;
    localparam int IDX_W     = 11;
    localparam int POS_W     = 11;
    localparam int ATTR_W    = 8;
    localparam int CELL_W    = CHAR_W + ATTR_W;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_TEXT_ATTR = 1'b0;

    // function codes
    localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    // character codes and attribute reset
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_BLANK   = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCROLL,
        ST_FLUSH,
        ST_BLANK,
        ST_PUT,
        ST_READ,
        ST_DONE
    } tcw_state_t;

    typedef struct packed {
        logic home;
        logic advance;
        logic newline;
        logic row_up;
    } cur_cmd_t;

endpackage
`default_nettype wire

### rtl/tcw_screen_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_screen_mem
// Screen cell store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tcw_screen_mem #(
    parameter int DEPTH = 2000,
    parameter int WIDTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

### rtl/tcw_cursor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_cursor
// Cursor unit: cell index plus column, stepped by commands from the sequencer.
// ----------------------------------------------------------------------------
module tcw_cursor #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int CW      = $clog2(COLUMNS * ROWS + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire tcw_pkg::cur_cmd_t cmd,
    output logic      [CW-1:0]    cursor,
    output logic                  at_end
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int COL_W = $clog2(COLUMNS);

    logic [CW-1:0]    pos_reg, pos_next;
    logic [COL_W-1:0] col_reg, col_next;

    always_comb
    begin
        pos_next = pos_reg;
        col_next = col_reg;
        if (cmd.home)
        begin
            pos_next = '0;
            col_next = '0;
        end
        else if (cmd.row_up)
        begin
            pos_next = pos_reg - CW'(COLUMNS);
        end
        else if (cmd.newline)
        begin
            // start of next row
            pos_next = pos_reg - CW'(col_reg) + CW'(COLUMNS);
            col_next = '0;
        end
        else if (cmd.advance)
        begin
            pos_next = pos_reg + CW'(1);
            if (col_reg == COL_W'(COLUMNS - 1))
            begin
                col_next = '0;
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            col_reg <= col_next;
        end
    end

    assign cursor = pos_reg;
    assign at_end = (pos_reg == CW'(CELLS));

endmodule
`default_nettype wire

### rtl/tcw_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer: walks the shared address counter over the screen store for
// scroll and clear, writes characters, reads cells and holds the result word.
// ----------------------------------------------------------------------------
module tcw_ctrl #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int AW      = $clog2(COLUMNS * ROWS),
    parameter int CW      = $clog2(COLUMNS * ROWS + 1)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [tcw_pkg::FUNC_W-1:0]  in_func,
    input  wire logic [tcw_pkg::CHAR_W-1:0]  in_char,
    input  wire logic [tcw_pkg::IDX_W-1:0]   in_index,
    input  wire logic [tcw_pkg::ATTR_W-1:0]  attr,
    input  wire logic [CW-1:0]               cursor,
    input  wire logic                        at_end,
    output tcw_pkg::cur_cmd_t                cur_cmd,
    output logic                             mem_we,
    output logic      [AW-1:0]               mem_waddr,
    output logic      [tcw_pkg::CELL_W-1:0]  mem_wdata,
    output logic                             mem_re,
    output logic      [AW-1:0]               mem_raddr,
    input  wire logic [tcw_pkg::CELL_W-1:0]  mem_rdata,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic      [tcw_pkg::POS_W-1:0]   out_pos,
    output logic      [tcw_pkg::CHAR_W-1:0]  out_char,
    output logic      [tcw_pkg::ATTR_W-1:0]  out_attr
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam logic [AW-1:0] LAST_COPY  = AW'(CELLS - COLUMNS - 1);
    localparam logic [AW-1:0] FIRST_LAST = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);

    tcw_state_t state_reg, state_next;

    logic [FUNC_W-1:0] func_reg, func_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              in_range_reg, in_range_next;
    logic [AW-1:0]     cnt_reg, cnt_next;
    logic              copy_pend_reg, copy_pend_next;
    logic [AW-1:0]     copy_addr_reg, copy_addr_next;
    logic              out_valid_reg, out_valid_next;
    logic [POS_W-1:0]  out_pos_reg, out_pos_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic [ATTR_W-1:0] out_attr_reg, out_attr_next;

    logic                   accept;
    logic                   out_free;
    logic [IDX_W+AW-1:0]    idx_ext;
    logic [POS_W+CW-1:0]    pos_ext;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign idx_ext  = (IDX_W + AW)'(idx_reg);
    assign pos_ext  = (POS_W + CW)'(cursor);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_func)
                        FUNC_PUT:   state_next = at_end ? ST_SCROLL : ST_PUT;
                        FUNC_CLEAR: state_next = ST_BLANK;
                        FUNC_READ:  state_next = ST_READ;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_SCROLL:
            begin
                if (cnt_reg == LAST_COPY)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_BLANK;
            end
            ST_BLANK:
            begin
                if (cnt_reg == LAST_CELL)
                begin
                    state_next = (func_reg == FUNC_CLEAR) ? ST_DONE : ST_PUT;
                end
            end
            ST_PUT:
            begin
                state_next = ST_DONE;
            end
            ST_READ:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        func_next      = func_reg;
        char_next      = char_reg;
        idx_next       = idx_reg;
        in_range_next  = in_range_reg;
        cnt_next       = cnt_reg;
        copy_pend_next = copy_pend_reg;
        copy_addr_next = copy_addr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_pos_next   = out_pos_reg;
        out_char_next  = out_char_reg;
        out_attr_next  = out_attr_reg;
        cur_cmd        = '0;
        mem_we         = 1'b0;
        mem_waddr      = cnt_reg;
        mem_wdata      = {attr, CHAR_BLANK};
        mem_re         = 1'b0;
        mem_raddr      = cnt_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    func_next     = in_func;
                    char_next     = in_char;
                    idx_next      = in_index;
                    in_range_next = (32'(in_index) < 32'(CELLS));
                    cnt_next      = '0;
                    copy_pend_next = 1'b0;
                    cur_cmd.home  = (in_func == FUNC_CLEAR);
                end
            end
            ST_SCROLL:
            begin
                // read one row ahead, write the word fetched last cycle
                mem_re         = 1'b1;
                mem_raddr      = cnt_reg + AW'(COLUMNS);
                mem_we         = copy_pend_reg;
                mem_waddr      = copy_addr_reg;
                mem_wdata      = mem_rdata;
                copy_pend_next = 1'b1;
                copy_addr_next = cnt_reg;
                cnt_next       = cnt_reg + AW'(1);
            end
            ST_FLUSH:
            begin
                mem_we         = copy_pend_reg;
                mem_waddr      = copy_addr_reg;
                mem_wdata      = mem_rdata;
                copy_pend_next = 1'b0;
                cnt_next       = FIRST_LAST;
                cur_cmd.row_up = 1'b1;
            end
            ST_BLANK:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = {attr, CHAR_BLANK};
                cnt_next  = cnt_reg + AW'(1);
            end
            ST_PUT:
            begin
                if (char_reg == CHAR_NEWLINE)
                begin
                    cur_cmd.newline = 1'b1;
                end
                else
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = cursor[AW-1:0];
                    mem_wdata       = {attr, char_reg};
                    cur_cmd.advance = 1'b1;
                end
            end
            ST_READ:
            begin
                mem_re    = 1'b1;
                mem_raddr = idx_ext[AW-1:0];
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_pos_next   = pos_ext[POS_W-1:0];
                    if ((func_reg == FUNC_READ) && in_range_reg)
                    begin
                        out_char_next = mem_rdata[CHAR_W-1:0];
                        out_attr_next = mem_rdata[CELL_W-1:CHAR_W];
                    end
                    else
                    begin
                        out_char_next = '0;
                        out_attr_next = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            copy_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            copy_pend_reg <= copy_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        char_reg      <= char_next;
        idx_reg       <= idx_next;
        in_range_reg  <= in_range_next;
        cnt_reg       <= cnt_next;
        copy_addr_reg <= copy_addr_next;
        out_pos_reg   <= out_pos_next;
        out_char_reg  <= out_char_next;
        out_attr_reg  <= out_attr_next;
    end

    assign out_valid = out_valid_reg;
    assign out_pos   = out_pos_reg;
    assign out_char  = out_char_reg;
    assign out_attr  = out_attr_reg;

endmodule
`default_nettype wire

### rtl/text_console_writer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer
// Teletype writer for a COLUMNS x ROWS text screen of character/attribute cells.
//
// Input words (s_*): tuser carries the function (put, clear, read), tdata the
// character and the cell index to read. One result word (m_*) per input word:
// cursor position after the item, plus the cell contents for a read.
// The attribute register at byte address 0 of the APB port colours every
// character and blank written; change it only while the block is idle.
//
// Steps from acceptance to the result word:
//   unused function                  : result step only
//   read, plain put                  : cell read or write, result step
//   clear                            : blank walk over every cell, result
//   put with the cursor past the end : scroll, flush, blank last row, put
// The walks go through the screen store one cell per cycle on its single
// write port; s_tready stays low until the result word is registered.
// A new word is taken while the previous result still waits on m_tready;
// a stalled receiver holds the block in its final step until it drains.
// Reset homes the cursor and sets the attribute to 0x0F; the screen store is
// not cleared, so issue a clear before reading cells.
// ----------------------------------------------------------------------------
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // slave stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [7:0] char_code, [18:8] cell_index, [23:19] zero
    input  wire logic [tcw_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] func
    input  wire logic [tcw_pkg::FUNC_W-1:0]    s_tuser,
    // master stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [10:0] cursor_position, [18:11] read_char, [26:19] read_attribute,
    // [31:27] zero
    output logic      [tcw_pkg::M_TDATA_W-1:0] m_tdata,
    // APB configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tcw_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [tcw_pkg::PDATA_W-1:0]   pwdata,
    output logic      [tcw_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(CELLS + 1);

    logic [ATTR_W-1:0] attr_reg, attr_next;
    logic              cfg_write;

    logic [CW-1:0]     cursor;
    logic              at_end;
    cur_cmd_t          cur_cmd;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [CELL_W-1:0] mem_rdata;
    logic [POS_W-1:0]  out_pos;
    logic [CHAR_W-1:0] out_char;
    logic [ATTR_W-1:0] out_attr;

    // configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == REG_TEXT_ATTR);
    assign attr_next = cfg_write ? pwdata[ATTR_W-1:0] : attr_reg;
    assign prdata    = (paddr[2] == REG_TEXT_ATTR) ? PDATA_W'(attr_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_RESET;
        end
        else
        begin
            attr_reg <= attr_next;
        end
    end

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .AW      (AW),
        .CW      (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_func   (s_tuser),
        .in_char   (s_tdata[CHAR_W-1:0]),
        .in_index  (s_tdata[CHAR_W+IDX_W-1:CHAR_W]),
        .attr      (attr_reg),
        .cursor    (cursor),
        .at_end    (at_end),
        .cur_cmd   (cur_cmd),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pos   (out_pos),
        .out_char  (out_char),
        .out_attr  (out_attr)
    );

    tcw_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .CW      (CW)
    ) u_cursor (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cur_cmd),
        .cursor (cursor),
        .at_end (at_end)
    );

    tcw_screen_mem #(
        .DEPTH (CELLS),
        .WIDTH (CELL_W),
        .AW    (AW)
    ) u_screen (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign m_tdata = M_TDATA_W'({out_attr, out_char, out_pos});

`ifndef SYNTHESIS
    // cursor never runs beyond the past-end position
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(cursor) <= 32'(CELLS))
        else $error("cursor beyond past-end position");

    // an accepted word keeps the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken again while busy");

    // the screen store is written only while an item is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !s_tready)
        else $error("screen write while idle");
`endif

endmodule
`default_nettype wire
